>>> hw/rtl/ttrc_pkg.sv
`timescale 1ns / 1ps

package ttrc_pkg;

	typedef logic [15:0] term_t;
	typedef logic [7:0]  pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} msg_item_t;

	localparam term_t FIRST_OFFSET = 16'd7;
	localparam term_t TERM_ONE     = 16'd1;
	localparam term_t CK_MOD       = 16'hFFFF;
	localparam pos_t  ALPHA_STEP   = 8'd17;
	localparam pos_t  BETA_STEP    = 8'd31;
	localparam pos_t  POS_FIRST    = 8'd1;

	// A multiple of the modulus that exceeds any subtrahend, so the difference stays positive.
	localparam logic [25:0] MOD_BIAS = 26'd16776960;

endpackage

>>> hw/rtl/ttrc_msg_if.sv
`timescale 1ns / 1ps

interface ttrc_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

>>> hw/rtl/ttrc_sum_if.sv
`timescale 1ns / 1ps

interface ttrc_sum_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink (input valid, input checksum, output ready);
endinterface

>>> hw/rtl/ttrc_term_calc.sv
`timescale 1ns / 1ps

module ttrc_term_calc (
	input  logic [7:0]      data_byte,
	input  ttrc_pkg::pos_t  pos,
	input  ttrc_pkg::term_t cur,
	input  ttrc_pkg::term_t prev,
	output ttrc_pkg::term_t next_term
);
	import ttrc_pkg::*;

	pos_t        alpha;
	pos_t        beta;
	logic [8:0]  coef;
	logic [24:0] prod_a;
	logic [23:0] prod_b;
	logic        borrow;
	logic [25:0] biased;
	logic [16:0] fold1;
	logic [15:0] fold2;

	always_comb begin
		alpha  = pos * ALPHA_STEP;
		beta   = pos * BETA_STEP;
		coef   = {1'b0, data_byte} + {1'b0, alpha};
		prod_a = coef * cur;
		prod_b = beta * prev;
		// A negative difference wraps in 64 bits, and 2^64 leaves one modulo 65535.
		borrow = prod_a < {1'b0, prod_b};
		biased = {1'b0, prod_a} - {2'b00, prod_b} + {25'd0, borrow} + MOD_BIAS;
		fold1  = {7'd0, biased[25:16]} + {1'b0, biased[15:0]};
		fold2  = {15'd0, fold1[16]} + fold1[15:0];
		next_term = (fold2 == CK_MOD) ? '0 : fold2;
	end
endmodule

>>> hw/rtl/three_term_recurrence_checksum_unit.sv
`timescale 1ns / 1ps

// Three-term recurrence checksum over a byte stream.
// The msg channel carries one message byte per beat with first_byte and
// last_byte marks; a first byte restarts the recurrence. The result channel
// carries one checksum beat for every last byte, in order.
// A byte beat is registered at acceptance; from that register the new term is
// computed by one pair of multipliers and a mod 65535 fold, and when the
// byte leaves it a checksum beat is loaded into the output register. A
// checksum is thus offered from the output register after its last byte
// has passed through the byte register.
// The unit accepts one byte per cycle unless a last byte waits behind a full output register.
// Reset clears both pipeline valids and sets the terms to one and the
// position to zero. When the result receiver stalls, the held checksum stays
// in the output register; bytes that are not last keep flowing, and ready
// drops only while a last byte waits behind a full output register.
module three_term_recurrence_checksum_unit (
	input logic         clk,
	input logic         arst_n,
	ttrc_msg_if.sink    msg,
	ttrc_sum_if.source  result
);
	import ttrc_pkg::*;

	msg_item_t item_s1;
	logic      valid_s1;
	logic      msg_fire;
	logic      s1_fire;
	logic      out_free;
	logic      out_valid_q;
	term_t     checksum_q;
	term_t     prev_q;
	term_t     cur_q;
	pos_t      pos_q;
	term_t     calc_term;
	term_t     next_cur;

	assign out_free  = !out_valid_q || result.ready;
	assign s1_fire   = valid_s1 && (!item_s1.last_byte || out_free);
	assign msg.ready = !valid_s1 || s1_fire;
	assign msg_fire  = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_fire) begin
			item_s1 <= '{data_byte: msg.data_byte, first_byte: msg.first_byte,
				last_byte: msg.last_byte};
		end
	end

	ttrc_term_calc u_term_calc (
		.data_byte (item_s1.data_byte),
		.pos       (pos_q),
		.cur       (cur_q),
		.prev      (prev_q),
		.next_term (calc_term)
	);

	assign next_cur = item_s1.first_byte ? ({8'd0, item_s1.data_byte} + FIRST_OFFSET)
		: calc_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= TERM_ONE;
			cur_q  <= TERM_ONE;
			pos_q  <= '0;
		end else if (s1_fire) begin
			prev_q <= item_s1.first_byte ? TERM_ONE : cur_q;
			cur_q  <= next_cur;
			pos_q  <= item_s1.first_byte ? POS_FIRST : pos_q + POS_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last_byte) begin
			checksum_q <= next_cur;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

	a_term_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != CK_MOD && prev_q != CK_MOD)
		else $error("recurrence term left the residue range");

	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && item_s1.first_byte |=> pos_q == POS_FIRST && prev_q == TERM_ONE)
		else $error("first byte did not restart the recurrence");

	a_terms_shift: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !item_s1.first_byte |=> prev_q == $past(cur_q))
		else $error("previous term did not take the old current term");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && item_s1.last_byte |=> result.valid && result.checksum == cur_q)
		else $error("last byte did not load the checksum beat");
endmodule

>>> tb/tb_three_term_recurrence_checksum_unit.sv
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum_unit;
	import ttrc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ttrc_msg_if msg_ch();
	ttrc_sum_if sum_ch();

	three_term_recurrence_checksum_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.result(sum_ch)
	);

	logic byte_valid = 1'b0;
	msg_item_t byte_beat = '0;
	logic sum_ready = 1'b0;

	assign msg_ch.valid = byte_valid;
	assign msg_ch.data_byte = byte_beat.data_byte;
	assign msg_ch.first_byte = byte_beat.first_byte;
	assign msg_ch.last_byte = byte_beat.last_byte;
	assign sum_ch.ready = sum_ready;

	msg_item_t pending_bytes[$];
	term_t expected_sums[$];

	term_t prev_term = TERM_ONE;
	term_t cur_term = TERM_ONE;
	pos_t byte_pos = '0;

	int byte_gap_pct = 0;
	int sum_stall_pct = 0;
	int byte_gap_left = 0;
	int sum_stall_left = 0;
	int error_count = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	function automatic term_t predict_term(logic [7:0] d, pos_t pos, term_t cur, term_t prev);
		pos_t alpha;
		pos_t beta;
		logic [63:0] prod_a;
		logic [63:0] prod_b;
		logic [63:0] modulus;
		alpha = pos * ALPHA_STEP;
		beta = pos * BETA_STEP;
		modulus = 64'(CK_MOD);
		prod_a = (64'(d) + 64'(alpha)) * 64'(cur);
		prod_b = 64'(beta) * 64'(prev);
		if (prod_a >= prod_b) begin
			return term_t'((prod_a - prod_b) % modulus);
		end
		// The 64-bit wrap of a negative difference adds one, since 2^64 mod 65535 is 1.
		return term_t'((64'd1 + modulus - ((prod_b - prod_a) % modulus)) % modulus);
	endfunction

	task automatic absorb_byte(msg_item_t beat);
		term_t next_val;
		if (beat.first_byte) begin
			prev_term = TERM_ONE;
			cur_term = term_t'(beat.data_byte) + FIRST_OFFSET;
			byte_pos = POS_FIRST;
		end else begin
			next_val = predict_term(beat.data_byte, byte_pos, cur_term, prev_term);
			prev_term = cur_term;
			cur_term = next_val;
			byte_pos = byte_pos + 8'd1;
		end
		if (beat.last_byte) begin
			expected_sums.push_back(cur_term);
		end
	endtask

	task automatic report_mismatch(string what);
		$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic push_byte(logic [7:0] d, logic f, logic l);
		msg_item_t beat;
		beat.data_byte = d;
		beat.first_byte = f;
		beat.last_byte = l;
		pending_bytes.push_back(beat);
	endtask

	function automatic logic [7:0] pick_data();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			return 8'h00;
		end else if (sel == 1) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_message(int len);
		for (int i = 0; i < len; i++) begin
			push_byte(pick_data(), i == 0, i == len - 1);
		end
	endtask

	task automatic push_random(int count);
		int pushed;
		int sel;
		int len;
		pushed = 0;
		while (pushed < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					push_byte(pick_data(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end else if (sel < 70) begin
				len = $urandom_range(1, 8);
				push_message(len);
			end else begin
				len = $urandom_range(9, 40);
				push_message(len);
			end
			pushed += len;
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || byte_valid || expected_sums.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && msg_ch.ready) begin
				absorb_byte(byte_beat);
			end
			if (!byte_valid || msg_ch.ready) begin
				if (byte_gap_left > 0) begin
					byte_gap_left--;
					byte_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					byte_beat <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
					if ($urandom_range(0, 99) < byte_gap_pct) begin
						byte_gap_left = $urandom_range(1, 14);
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		term_t want;
		if (!arst_n) begin
			sum_ready <= 1'b0;
		end else begin
			if (sum_ch.valid === 1'b1 && sum_ready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("unexpected checksum beat %0d", sum_ch.checksum));
				end else begin
					want = expected_sums.pop_front();
					if (sum_ch.checksum !== want) begin
						report_mismatch($sformatf("checksum %0d, expected %0d",
							sum_ch.checksum, want));
					end
				end
			end
			if (sum_stall_left > 0) begin
				sum_stall_left--;
				sum_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < sum_stall_pct) begin
				sum_stall_left = $urandom_range(1, 14) - 1;
				sum_ready <= 1'b0;
			end else begin
				sum_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("three_term_recurrence_checksum_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The recurrence runs on the reset state until the first marked byte arrives.
		byte_gap_pct = 20;
		sum_stall_pct = 20;
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b1);
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b1);
		push_byte(8'h11, 1'b0, 1'b0);
		push_byte(8'hC8, 1'b0, 1'b1);
		push_byte(8'h5A, 1'b1, 1'b1);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h01, 1'b1, 1'b0);
		push_byte(8'h02, 1'b1, 1'b0);
		push_byte(8'h03, 1'b0, 1'b1);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		wait_drained();

		byte_gap_pct = 25;
		sum_stall_pct = 10;
		push_random(30);
		// A message long enough for the position to wrap past 255.
		push_message(260);
		push_random(30);
		wait_drained();

		byte_gap_pct = 0;
		sum_stall_pct = 30;
		push_random(60);
		wait_drained();

		byte_gap_pct = 0;
		sum_stall_pct = 0;
		push_random(60);
		wait_drained();

		repeat (8) @(negedge clk);
		if (error_count == 0) begin
			$display("three_term_recurrence_checksum_unit regression: pass");
		end else begin
			$display("three_term_recurrence_checksum_unit regression: fail");
		end
		$finish;
	end

endmodule
